@@ rtl/core/sme_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sme_pkg: shared types and constants of the sliding-mode EMF observer
// Widths, rounding offsets, arctangent coefficients, register indexes and
// the sequencer state type.
// ----------------------------------------------------------------------------
package sme_pkg;

    localparam int DATA_W  = 16;
    localparam int SPEED_W = 27;
    localparam int ACC_W   = 40;
    localparam int MUL_W   = 18;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int DIV_W   = 32;
    localparam int DEN_W   = 16;
    localparam int IDX_W   = 8;

    // rounding offsets for half-up shifts
    localparam logic signed [ACC_W-1:0] RND8  = 40'sd128;
    localparam logic signed [ACC_W-1:0] RND14 = 40'sd8192;
    localparam logic signed [ACC_W-1:0] RND15 = 40'sd16384;
    localparam logic signed [ACC_W-1:0] RND16 = 40'sd32768;

    // arctangent polynomial, angle LSB = pi/32768
    localparam logic signed [MUL_W-1:0] ATAN_C3     = 18'sd2047;
    localparam logic signed [ACC_W-1:0] ATAN_C1     = 40'sd10240;
    localparam logic signed [MUL_W-1:0] OFF_EIGHTH  = 18'sd8192;
    localparam logic signed [MUL_W-1:0] OFF_3EIGHTH = 18'sd24576;
    localparam logic signed [MUL_W-1:0] MS_PER_S    = 18'sd1000;

    // error clamp, +/-1.0 in Q8.8
    localparam logic signed [MUL_W-1:0] ERR_ONE = 18'sd256;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_DECAY  = 8'd0;
    localparam logic [IDX_W-1:0] CFG_GAIN   = 8'd1;
    localparam logic [IDX_W-1:0] CFG_SLIDE  = 8'd2;
    localparam logic [IDX_W-1:0] CFG_FILTER = 8'd3;

    typedef enum logic [4:0] {
        S_IDLE, S_MA0, S_MA1, S_MB0, S_MB1, S_MB2, S_SW1,
        S_LA0, S_LA1, S_LB0, S_LB1, S_LB2,
        S_AT, S_AW, S_R0, S_R1, S_R2, S_R3, S_R4, S_R5, S_R6,
        S_SP0, S_SP1, S_SPW, S_SP2, S_OUT
    } state_t;

    // saturate a wide signed value to the data width
    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = 40'sd32767;
        lo = -40'sd32768;
        if (v > hi)
            return 16'sh7fff;
        else if (v < lo)
            return 16'sh8000;
        else
            return v[DATA_W-1:0];
    endfunction

endpackage

@@ rtl/core/sliding_mode_emf_observer.sv @@
`timescale 1ns / 1ps
// Sequence: the speed step and its divide run only when elapsed_ms is nonzero;
//   the angle divide runs for every item.
// Throughput: one item at a time; the next input is taken once the result
//   register has been loaded.
// Reset: observer state cleared except the rotor angle, registers at their defaults, no result held.
// ----------------------------------------------------------------------------
// sliding_mode_emf_observer: sliding-mode back-EMF and rotor angle observer
// One shared 18x18 multiplier and an iterative divider run under a sequencer:
// current model, switching term, EMF low-pass, polynomial atan2, speed.
// ----------------------------------------------------------------------------
module sliding_mode_emf_observer
(
    input  logic                      clk,
    input  logic                      rst_n,
    // config write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [sme_pkg::IDX_W-1:0] cfg_index,
    input  logic [15:0]               cfg_data,
    // input stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // volt_alpha, volt_beta, amps_alpha, amps_beta, elapsed_ms (16 each)
    input  logic [79:0]               s_tdata,
    // result stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // emf_alpha 16, emf_beta 16, rotor_angle 16, rotor_speed 27,
    // est_i_alpha 16, est_i_beta 16, zero pad 5
    output logic [111:0]              m_tdata
);

    localparam int DW = sme_pkg::DATA_W;
    localparam int MW = sme_pkg::MUL_W;
    localparam int AW = sme_pkg::ACC_W;
    localparam int SW = sme_pkg::SPEED_W;

    sme_pkg::state_t state_reg, state_next;

    // configuration
    logic signed [DW-1:0] decay_reg, gain_reg;
    logic [14:0]          slide_reg;
    logic [15:0]          filt_reg;

    // input item
    logic signed [DW-1:0] va_reg, vb_reg, ia_reg, ib_reg;
    logic [15:0]          el_reg;

    // observer state
    logic signed [DW-1:0] est_a_reg, est_b_reg, sw_a_reg, sw_b_reg;
    logic signed [DW-1:0] emf_a_reg, emf_b_reg, prev_reg, angle_reg;
    logic signed [SW-1:0] speed_reg;

    // datapath scratch
    logic signed [sme_pkg::PROD_W-1:0] prod_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [MW-1:0] r_reg, rsq_reg, t_reg, off_reg;
    logic                 yneg_reg, qneg_reg;

    // result register
    logic         m_valid_reg;
    logic [111:0] m_data_reg;

    // shared multiplier operands and derived values
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [AW-1:0] prod_ext, sum14, sum16, p8, p15;
    logic signed [AW-1:0] d_a, d_b, e_raw_a, e_raw_b;
    logic signed [MW-1:0] e_a, e_b;
    logic [16:0]          kc;
    logic signed [MW-1:0] ay, xs, num, den, num_mag, ang, ang_fin;
    logic signed [MW-1:0] q_sgn;
    logic signed [sme_pkg::PROD_W-1:0] prod_mag;
    logic signed [SW-1:0] speed_sgn;

    // divider hookup
    logic                      div_start, div_busy;
    logic [sme_pkg::DIV_W-1:0] div_dividend, div_quo;
    logic [sme_pkg::DEN_W-1:0] div_divisor;

    sme_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = state_reg == sme_pkg::S_IDLE;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // derived arithmetic
    always_comb
    begin
        prod_ext = AW'(prod_reg);
        sum14    = (acc_reg + prod_ext + sme_pkg::RND14) >>> 14;
        sum16    = (acc_reg + prod_ext + sme_pkg::RND16) >>> 16;
        p8       = (prod_ext + sme_pkg::RND8) >>> 8;
        p15      = (prod_ext + sme_pkg::RND15) >>> 15;
        kc       = 17'h10000 - {1'b0, filt_reg};

        // voltage minus switching term
        d_a = AW'(sme_pkg::sat_data(AW'(va_reg) - AW'(sw_a_reg)));
        d_b = AW'(sme_pkg::sat_data(AW'(vb_reg) - AW'(sw_b_reg)));

        // current error clamped to +/-1.0
        e_raw_a = AW'(est_a_reg) - AW'(ia_reg);
        e_raw_b = AW'(est_b_reg) - AW'(ib_reg);
        if (e_raw_a > AW'(sme_pkg::ERR_ONE))
            e_a = sme_pkg::ERR_ONE;
        else if (e_raw_a < -AW'(sme_pkg::ERR_ONE))
            e_a = -sme_pkg::ERR_ONE;
        else
            e_a = e_raw_a[MW-1:0];
        if (e_raw_b > AW'(sme_pkg::ERR_ONE))
            e_b = sme_pkg::ERR_ONE;
        else if (e_raw_b < -AW'(sme_pkg::ERR_ONE))
            e_b = -sme_pkg::ERR_ONE;
        else
            e_b = e_raw_b[MW-1:0];

        // atan2 ratio setup, y = emf alpha, x = emf beta
        xs = MW'(emf_b_reg);
        ay = emf_a_reg < 0 ? -MW'(emf_a_reg) : MW'(emf_a_reg);
        if (emf_a_reg == 16'sd0 && emf_b_reg == 16'sd0)
            ay = 18'sd1;
        if (!emf_b_reg[DW-1])
        begin
            num = xs - ay;
            den = xs + ay;
        end
        else
        begin
            num = xs + ay;
            den = ay - xs;
        end
        num_mag = num < 0 ? -num : num;

        // speed dividend magnitude
        prod_mag = prod_reg < 0 ? -prod_reg : prod_reg;

        // signed quotients
        q_sgn     = qneg_reg ? -{1'b0, div_quo[16:0]} : {1'b0, div_quo[16:0]};
        speed_sgn = qneg_reg ? -{1'b0, div_quo[SW-2:0]} : {1'b0, div_quo[SW-2:0]};

        // final angle before negation and saturation
        ang     = MW'(p15) + off_reg;
        ang_fin = yneg_reg ? ang : -ang;

        // divider feed
        div_start = state_reg == sme_pkg::S_AT || state_reg == sme_pkg::S_SP1;
        if (state_reg == sme_pkg::S_AT)
        begin
            div_dividend = {num_mag[16:0], 15'd0};
            div_divisor  = den[sme_pkg::DEN_W-1:0];
        end
        else
        begin
            div_dividend = prod_mag[sme_pkg::DIV_W-1:0];
            div_divisor  = el_reg;
        end
    end

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            sme_pkg::S_MA0: begin mul_a = MW'(decay_reg); mul_b = MW'(est_a_reg); end
            sme_pkg::S_MA1: begin mul_a = MW'(gain_reg);  mul_b = d_a[MW-1:0]; end
            sme_pkg::S_MB0: begin mul_a = MW'(decay_reg); mul_b = MW'(est_b_reg); end
            sme_pkg::S_MB1: begin mul_a = MW'(gain_reg);  mul_b = d_b[MW-1:0]; end
            sme_pkg::S_MB2: begin mul_a = {3'd0, slide_reg}; mul_b = e_a; end
            sme_pkg::S_SW1: begin mul_a = {3'd0, slide_reg}; mul_b = e_b; end
            sme_pkg::S_LA0: begin mul_a = {1'b0, kc}; mul_b = MW'(emf_a_reg); end
            sme_pkg::S_LA1: begin mul_a = {2'd0, filt_reg}; mul_b = MW'(sw_a_reg); end
            sme_pkg::S_LB0: begin mul_a = {1'b0, kc}; mul_b = MW'(emf_b_reg); end
            sme_pkg::S_LB1: begin mul_a = {2'd0, filt_reg}; mul_b = MW'(sw_b_reg); end
            sme_pkg::S_R1:  begin mul_a = r_reg; mul_b = r_reg; end
            sme_pkg::S_R3:  begin mul_a = sme_pkg::ATAN_C3; mul_b = rsq_reg; end
            sme_pkg::S_R5:  begin mul_a = t_reg; mul_b = r_reg; end
            sme_pkg::S_SP0:
            begin
                mul_a = MW'(angle_reg) - MW'(prev_reg);
                mul_b = sme_pkg::MS_PER_S;
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sme_pkg::S_IDLE: if (s_tvalid) state_next = sme_pkg::S_MA0;
            sme_pkg::S_MA0:  state_next = sme_pkg::S_MA1;
            sme_pkg::S_MA1:  state_next = sme_pkg::S_MB0;
            sme_pkg::S_MB0:  state_next = sme_pkg::S_MB1;
            sme_pkg::S_MB1:  state_next = sme_pkg::S_MB2;
            sme_pkg::S_MB2:  state_next = sme_pkg::S_SW1;
            sme_pkg::S_SW1:  state_next = sme_pkg::S_LA0;
            sme_pkg::S_LA0:  state_next = sme_pkg::S_LA1;
            sme_pkg::S_LA1:  state_next = sme_pkg::S_LB0;
            sme_pkg::S_LB0:  state_next = sme_pkg::S_LB1;
            sme_pkg::S_LB1:  state_next = sme_pkg::S_LB2;
            sme_pkg::S_LB2:  state_next = sme_pkg::S_AT;
            sme_pkg::S_AT:   state_next = sme_pkg::S_AW;
            sme_pkg::S_AW:   if (!div_busy) state_next = sme_pkg::S_R0;
            sme_pkg::S_R0:   state_next = sme_pkg::S_R1;
            sme_pkg::S_R1:   state_next = sme_pkg::S_R2;
            sme_pkg::S_R2:   state_next = sme_pkg::S_R3;
            sme_pkg::S_R3:   state_next = sme_pkg::S_R4;
            sme_pkg::S_R4:   state_next = sme_pkg::S_R5;
            sme_pkg::S_R5:   state_next = sme_pkg::S_R6;
            sme_pkg::S_R6:   state_next = el_reg != 16'd0 ? sme_pkg::S_SP0 : sme_pkg::S_OUT;
            sme_pkg::S_SP0:  state_next = sme_pkg::S_SP1;
            sme_pkg::S_SP1:  state_next = sme_pkg::S_SPW;
            sme_pkg::S_SPW:  if (!div_busy) state_next = sme_pkg::S_SP2;
            sme_pkg::S_SP2:  state_next = sme_pkg::S_OUT;
            sme_pkg::S_OUT:  if (!m_valid_reg || m_tready) state_next = sme_pkg::S_IDLE;
            default:         state_next = sme_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= sme_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration registers, observer state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg   <= 16'sd0;
            gain_reg    <= 16'sd16384;
            slide_reg   <= 15'd6144;
            filt_reg    <= 16'd26214;
            est_a_reg   <= '0;
            est_b_reg   <= '0;
            sw_a_reg    <= '0;
            sw_b_reg    <= '0;
            emf_a_reg   <= '0;
            emf_b_reg   <= '0;
            prev_reg    <= '0;
            speed_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    sme_pkg::CFG_DECAY:  decay_reg <= cfg_data;
                    sme_pkg::CFG_GAIN:   gain_reg  <= cfg_data;
                    sme_pkg::CFG_SLIDE:  slide_reg <= cfg_data[14:0];
                    sme_pkg::CFG_FILTER: filt_reg  <= cfg_data;
                    default: ;
                endcase
            end
            // result valid: load on a free slot, drop after the transfer
            if (state_reg == sme_pkg::S_OUT && (!m_valid_reg || m_tready))
                m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_tready)
                m_valid_reg <= 1'b0;
            unique case (state_reg)
                sme_pkg::S_MB0: est_a_reg <= sme_pkg::sat_data(sum14);
                sme_pkg::S_MB2: est_b_reg <= sme_pkg::sat_data(sum14);
                sme_pkg::S_SW1: sw_a_reg  <= sme_pkg::sat_data(p8);
                sme_pkg::S_LA0: sw_b_reg  <= sme_pkg::sat_data(p8);
                sme_pkg::S_LB0: emf_a_reg <= sme_pkg::sat_data(sum16);
                sme_pkg::S_LB2: emf_b_reg <= sme_pkg::sat_data(sum16);
                sme_pkg::S_SP2:
                begin
                    speed_reg <= speed_sgn;
                    prev_reg  <= angle_reg;
                end
                default: ;
            endcase
        end
    end

    // payload and scratch registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            sme_pkg::S_IDLE:
                if (s_tvalid)
                begin
                    va_reg <= s_tdata[15:0];
                    vb_reg <= s_tdata[31:16];
                    ia_reg <= s_tdata[47:32];
                    ib_reg <= s_tdata[63:48];
                    el_reg <= s_tdata[79:64];
                end
            sme_pkg::S_MA1, sme_pkg::S_MB1, sme_pkg::S_LA1, sme_pkg::S_LB1:
                acc_reg <= prod_ext;
            sme_pkg::S_AT:
            begin
                off_reg  <= emf_b_reg[DW-1] ? sme_pkg::OFF_3EIGHTH : sme_pkg::OFF_EIGHTH;
                yneg_reg <= emf_a_reg[DW-1];
                qneg_reg <= num[MW-1];
            end
            sme_pkg::S_R0: r_reg   <= q_sgn;
            sme_pkg::S_R2: rsq_reg <= MW'(p15);
            sme_pkg::S_R4: t_reg   <= MW'(p15 - sme_pkg::ATAN_C1);
            sme_pkg::S_R6: angle_reg <= sme_pkg::sat_data(AW'(ang_fin));
            sme_pkg::S_SP1: qneg_reg <= prod_reg[sme_pkg::PROD_W-1];
            sme_pkg::S_OUT:
                if (!m_valid_reg || m_tready)
                    m_data_reg <= {5'd0, est_b_reg, est_a_reg, speed_reg, angle_reg,
                                   emf_b_reg, emf_a_reg};
            default: ;
        endcase
    end

endmodule

@@ rtl/core/sme_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sme_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sme_div
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [sme_pkg::DIV_W-1:0] dividend,
    input  logic [sme_pkg::DEN_W-1:0] divisor,
    output logic                      busy,
    output logic [sme_pkg::DIV_W-1:0] quotient
);

    logic [5:0]                cnt_reg, cnt_next;
    logic [sme_pkg::DIV_W-1:0] quo_reg, quo_next;
    logic [sme_pkg::DEN_W-1:0] rem_reg, rem_next;
    logic [sme_pkg::DEN_W-1:0] den_reg, den_next;
    logic [sme_pkg::DEN_W:0]   shifted;
    logic [sme_pkg::DEN_W:0]   trial;
    logic                      ge;

    // one restoring step
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[sme_pkg::DIV_W-1]};
        trial    = shifted - {1'b0, den_reg};
        ge       = shifted >= {1'b0, den_reg};
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        if (start)
        begin
            cnt_next = 6'(sme_pkg::DIV_W);
            quo_next = dividend;
            rem_next = '0;
            den_next = divisor;
        end
        else if (cnt_reg != 6'd0)
        begin
            cnt_next = cnt_reg - 6'd1;
            quo_next = {quo_reg[sme_pkg::DIV_W-2:0], ge};
            rem_next = ge ? trial[sme_pkg::DEN_W-1:0] : shifted[sme_pkg::DEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy     = cnt_reg != 6'd0;
    assign quotient = quo_reg;

endmodule
